@@ rtl/qft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_pkg
// Types, constants and register indexes shared by the quoted field tokenizer.
// ----------------------------------------------------------------------------
package qft_pkg;

  localparam int unsigned QFT_MAX_DELIM   = 8;
  localparam int unsigned QFT_DELIM_BITS  = 64;
  localparam int unsigned QFT_CFG_IDX_W   = 8;
  localparam logic [7:0]  QFT_QUOTE_BYTE  = 8'h22;

  typedef enum logic [QFT_CFG_IDX_W-1:0] {
    CFG_DELIM_CHARS  = 8'd0,
    CFG_DELIM_COUNT  = 8'd1,
    CFG_FIELD_LIMIT  = 8'd2,
    CFG_MERGE_ADJ    = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] field_byte;
    logic       field_byte_valid;
    logic       field_end;
    logic       line_done;
  } out_item_t;

  typedef struct packed {
    logic [QFT_DELIM_BITS-1:0] delimiter_chars;
    logic [3:0]                delimiter_count;
    logic [7:0]                field_limit;
    logic                      merge_adjacent;
  } cfg_t;

  typedef struct packed {
    logic       in_quote;
    logic       field_has_bytes;
    logic [7:0] fields_emitted;
    logic       limit_reached;
  } line_state_t;

endpackage

@@ rtl/qft_delim_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_delim_match
// Compares one byte against the configured delimiter set in parallel.
// ----------------------------------------------------------------------------
module qft_delim_match
  import qft_pkg::*;
#(
  parameter int unsigned MAX_DELIMITERS = QFT_MAX_DELIM
) (
  input  logic [7:0]                byte_in,
  input  logic [QFT_DELIM_BITS-1:0] delimiter_chars,
  input  logic [3:0]                delimiter_count,
  output logic                      is_delim
);

  localparam logic [3:0] MaxCount = 4'(MAX_DELIMITERS);

  logic [3:0]                count_eff;
  logic [MAX_DELIMITERS-1:0] hit;

  // Counts above the supported number of slots use all slots.
  assign count_eff = (delimiter_count > MaxCount) ? MaxCount : delimiter_count;

  always_comb begin
    for (int i = 0; i < MAX_DELIMITERS; i++) begin
      hit[i] = (4'(i) < count_eff) && (delimiter_chars[8*i +: 8] == byte_in);
    end
  end

  assign is_delim = |hit;

endmodule

@@ rtl/qft_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_core
// Per-byte field decision and the line state registers.
// ----------------------------------------------------------------------------
module qft_core
  import qft_pkg::*;
#(
  parameter int unsigned MAX_DELIMITERS = QFT_MAX_DELIM
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  in_item_t    item,
  input  cfg_t        cfg,
  output out_item_t   result,
  output logic        result_any,
  output line_state_t state
);

  line_state_t st_r;
  line_state_t st_nxt;
  logic        is_delim;
  logic        raw_mode;
  logic        valid;
  logic        fend;
  logic [7:0]  fe_inc;

  qft_delim_match #(
    .MAX_DELIMITERS (MAX_DELIMITERS)
  ) u_match (
    .byte_in         (item.in_byte),
    .delimiter_chars (cfg.delimiter_chars),
    .delimiter_count (cfg.delimiter_count),
    .is_delim        (is_delim)
  );

  assign raw_mode = st_r.limit_reached || (cfg.field_limit == 8'd1);
  assign fe_inc   = (st_r.fields_emitted == 8'hFF) ? 8'hFF : st_r.fields_emitted + 8'd1;

  always_comb begin
    st_nxt = st_r;
    valid  = 1'b0;
    fend   = 1'b0;
    if (item.byte_present) begin
      if (raw_mode) begin
        valid = 1'b1;
      end else if (item.in_byte == QFT_QUOTE_BYTE) begin
        // A closing quote always ends a field, even an empty one.
        if (st_r.in_quote) begin
          fend                   = 1'b1;
          st_nxt.fields_emitted  = fe_inc;
          st_nxt.field_has_bytes = 1'b0;
        end
        st_nxt.in_quote = !st_r.in_quote;
      end else if (st_r.in_quote) begin
        valid = 1'b1;
      end else if (is_delim) begin
        if (st_r.field_has_bytes || !cfg.merge_adjacent) begin
          fend                   = 1'b1;
          st_nxt.fields_emitted  = fe_inc;
          st_nxt.field_has_bytes = 1'b0;
        end
        // The limit is only checked right after a delimiter, as an exact match.
        if ((cfg.field_limit > 8'd1) &&
            (st_nxt.fields_emitted == cfg.field_limit - 8'd1)) begin
          st_nxt.limit_reached = 1'b1;
        end
      end else begin
        valid = 1'b1;
      end
      if (valid) begin
        st_nxt.field_has_bytes = 1'b1;
      end
    end
    if (item.line_end) begin
      if (st_nxt.field_has_bytes) begin
        fend = 1'b1;
      end
      st_nxt = '0;
    end
  end

  always_comb begin
    result.field_byte       = valid ? item.in_byte : 8'd0;
    result.field_byte_valid = valid;
    result.field_end        = fend;
    result.line_done        = item.line_end;
    result_any              = valid || fend || item.line_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

  assign state = st_r;

endmodule

@@ rtl/qft_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_out_reg
// Result register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module qft_out_reg
  import qft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_data,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  // The register can take a new result when empty or when its content leaves now.
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/quoted_field_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_field_tokenizer
// Splits a byte stream into quoted or delimited fields, one byte per item.
// ----------------------------------------------------------------------------
//  Channel   Ports                              Payload
//  input     in_valid / in_ready / in_data      in_item_t, one byte or bare end
//  result    out_valid / out_ready / out_data   out_item_t, zero or one per item
//  config    cfg_valid / cfg_ready              cfg_index, cfg_wdata (64 bit)
//
// An item is taken into the input register, decided combinationally and its
// result placed in the result register, one item per cycle sustained while
// the result side takes results. The loop through the line state registers
// sets the rate. Reset clears the valid flags and the line state and loads
// the register defaults. A stalled result register holds the input stage,
// which then fills and drops in_ready. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module quoted_field_tokenizer
  import qft_pkg::*;
#(
  parameter int unsigned MAX_DELIMITERS = QFT_MAX_DELIM
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [QFT_CFG_IDX_W-1:0] cfg_index,
  input  logic [QFT_DELIM_BITS-1:0] cfg_wdata
);

  cfg_t        cfg_r;
  logic        in_v_r;
  logic        in_v_nxt;
  in_item_t    in_r;
  logic        step_en;
  logic        out_free;
  logic        res_any;
  out_item_t   res;
  line_state_t state;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter_chars <= QFT_DELIM_BITS'(32);
      cfg_r.delimiter_count <= 4'd1;
      cfg_r.field_limit     <= 8'd0;
      cfg_r.merge_adjacent  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DELIM_CHARS: cfg_r.delimiter_chars <= cfg_wdata;
        CFG_DELIM_COUNT: cfg_r.delimiter_count <= cfg_wdata[3:0];
        CFG_FIELD_LIMIT: cfg_r.field_limit     <= cfg_wdata[7:0];
        CFG_MERGE_ADJ:   cfg_r.merge_adjacent  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register: an item advances when the result register can take it.
  assign step_en  = in_v_r && out_free;
  assign in_ready = !in_v_r || step_en;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end else if (step_en) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  qft_core #(
    .MAX_DELIMITERS (MAX_DELIMITERS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .item       (in_r),
    .cfg        (cfg_r),
    .result     (res),
    .result_any (res_any),
    .state      (state)
  );

  qft_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en && res_any),
    .load_data (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // A result always carries a byte, a field end or a line end.
  a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.field_byte_valid || out_data.field_end || out_data.line_done))
    else $error("empty result item");

  // A result without a byte shows a zero byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.field_byte_valid) |-> (out_data.field_byte == 8'd0))
    else $error("stray field byte");

  // A line end clears all line state.
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && in_r.line_end) |=> (state == '0))
    else $error("line state not cleared at line end");

  // The input side only stalls while an item waits in the input register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_v_r && out_valid && !out_ready))
    else $error("input stalled without cause");
`endif

endmodule
